### rtl/clws_pkg.sv
// Shared types and constants for the character-LCD write sequencer.
// No dependencies; imported by char_lcd_write_sequencer_unit.
package clws_pkg;

  // Bits of the number field that are printed (two's complement).
  localparam int NUMBER_WIDTH = 32;
  // Decimal digits that cover the unsigned magnitude.
  localparam int DIGITS       = (NUMBER_WIDTH * 30103) / 100000 + 1;
  localparam int BCD_W        = DIGITS * 4;
  localparam int CONV_CNT_W   = $clog2(NUMBER_WIDTH + 1);
  localparam int DIGIT_CNT_W  = $clog2(DIGITS + 1);

  localparam int CMD_W        = 3;
  localparam int IN_DATA_W    = 48;
  localparam int LIST_DEPTH   = 5;
  localparam int LIST_CNT_W   = $clog2(LIST_DEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE_CMD  = 3'd0,
    CMD_WRITE_DATA = 3'd1,
    CMD_NUMBER     = 3'd2,
    CMD_CURSOR     = 3'd3,
    CMD_INIT       = 3'd4
  } command_t;

  // One queued bus byte; a bare item goes out as a single strobe in either mode.
  typedef struct packed {
    logic       bare;
    logic       rs;
    logic [7:0] data;
  } item_t;

  localparam logic [7:0] FUNC_SET_8BIT = 8'b0011_1000;
  localparam logic [7:0] DISPLAY_ON    = 8'b0000_1100;
  localparam logic [7:0] CLEAR_DISPLAY = 8'h01;
  localparam logic [7:0] NIB_FUNC_4BIT = 8'b0000_0010;
  localparam logic [7:0] NIB_LINES     = 8'b0000_1000;
  localparam logic [7:0] ASCII_ZERO    = 8'h30;
  localparam logic [7:0] ASCII_MINUS   = 8'h2D;

endpackage

### rtl/char_lcd_write_sequencer_unit.sv
// Character-LCD write sequencer: turns requests into LCD bus strobes.
// Depends on clws_pkg.
//
// One request is taken at a time, and s_tready is high only while the
// sequencer is idle; the final strobe may still sit in the output register
// when the next request is taken. Strobes leave at one per cycle while the
// sink is ready. Byte, cursor and init requests send one to seven strobes (a
// byte is two strobes in four-bit mode). A number request first runs a
// bit-serial binary-to-BCD conversion, one magnitude bit per cycle, then
// drops leading zero digits one per cycle (up to DIGITS-1 = 9), then sends
// up to eleven bytes, 22 strobes in four-bit mode. bus_mode resets to
// four-bit and should only be written idle.
module char_lcd_write_sequencer_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic                           cfg_wr_data,  // bus_mode
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // byte_value[7:0], number[39:8], column[45:40], row[46], zero[47]
  input  logic [clws_pkg::IN_DATA_W-1:0] s_tdata,
  input  logic [clws_pkg::CMD_W-1:0]     s_tuser,      // command
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,      // bus_value
  output logic                           m_tuser,      // reg_select
  output logic                           m_tlast       // last
);
  import clws_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CONV   = 5'b00010,
    ST_SKIP   = 5'b00100,
    ST_LIST   = 5'b01000,
    ST_DIGITS = 5'b10000
  } state_t;

  state_t                  state, state_next;
  logic                    bus_mode;
  logic [CONV_CNT_W-1:0]   conv_cnt, conv_cnt_next;
  logic [NUMBER_WIDTH-1:0] mag, mag_next;
  logic [BCD_W-1:0]        bcd, bcd_next;
  logic [DIGIT_CNT_W-1:0]  digits_left, digits_left_next;
  logic                    num_mode, num_mode_next;
  item_t                   list [LIST_DEPTH];
  item_t                   list_next [LIST_DEPTH];
  logic [LIST_CNT_W-1:0]   list_cnt, list_cnt_next;
  logic                    nib_phase, nib_phase_next;

  logic [7:0]              byte_value;
  logic [NUMBER_WIDTH-1:0] num_raw;
  logic [5:0]              column;
  logic                    row;
  command_t                cmd;
  logic                    accept, can_load, emit, split, item_done, strobe_last;
  item_t                   cur;
  logic [7:0]              cur_val;
  logic [3:0]              top_digit;
  logic [BCD_W-1:0]        bcd_adj;

  assign byte_value = s_tdata[7:0];
  assign num_raw    = s_tdata[8 +: NUMBER_WIDTH];
  assign column     = s_tdata[45:40];
  assign row        = s_tdata[46];
  assign cmd        = command_t'(s_tuser);

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign can_load = !m_tvalid || m_tready;
  assign top_digit = bcd[BCD_W-1 -: 4];

  // Double-dabble correction: each digit independently, before the shift.
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      bcd_adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? bcd[i*4 +: 4] + 4'd3 : bcd[i*4 +: 4];
    end
  end

  // Strobe currently at the head of the sequence.
  always_comb begin
    if (state == ST_DIGITS) begin
      cur = '{bare: 1'b0, rs: 1'b1, data: ASCII_ZERO | {4'h0, top_digit}};
    end else begin
      cur = list[0];
    end
    split     = bus_mode && !cur.bare;
    item_done = !split || nib_phase;
    if (!split) begin
      cur_val = cur.data;
    end else if (nib_phase) begin
      cur_val = {4'h0, cur.data[3:0]};
    end else begin
      cur_val = {4'h0, cur.data[7:4]};
    end
    emit = can_load && ((state == ST_LIST) || (state == ST_DIGITS));
    if (state == ST_DIGITS) begin
      strobe_last = item_done && (digits_left == DIGIT_CNT_W'(1));
    end else begin
      strobe_last = item_done && (list_cnt == LIST_CNT_W'(1)) && !num_mode;
    end
  end

  always_comb begin
    state_next       = state;
    conv_cnt_next    = conv_cnt;
    mag_next         = mag;
    bcd_next         = bcd;
    digits_left_next = digits_left;
    num_mode_next    = num_mode;
    list_cnt_next    = list_cnt;
    nib_phase_next   = nib_phase;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      list_next[i] = list[i];
    end

    case (state)
      ST_IDLE: begin
        if (accept) begin
          nib_phase_next = 1'b0;
          num_mode_next  = 1'b0;
          case (cmd)
            CMD_WRITE_CMD: begin
              list_next[0]  = '{bare: 1'b0, rs: 1'b0, data: byte_value};
              list_cnt_next = LIST_CNT_W'(1);
              state_next    = ST_LIST;
            end
            CMD_WRITE_DATA: begin
              list_next[0]  = '{bare: 1'b0, rs: 1'b1, data: byte_value};
              list_cnt_next = LIST_CNT_W'(1);
              state_next    = ST_LIST;
            end
            CMD_CURSOR: begin
              // 0x80 | (row ? 0x40 + column : column), column below 64
              list_next[0]  = '{bare: 1'b0, rs: 1'b0, data: {1'b1, row, column}};
              list_cnt_next = LIST_CNT_W'(1);
              state_next    = ST_LIST;
            end
            CMD_INIT: begin
              if (bus_mode) begin
                list_next[0]  = '{bare: 1'b1, rs: 1'b0, data: NIB_FUNC_4BIT};
                list_next[1]  = '{bare: 1'b1, rs: 1'b0, data: NIB_FUNC_4BIT};
                list_next[2]  = '{bare: 1'b1, rs: 1'b0, data: NIB_LINES};
                list_next[3]  = '{bare: 1'b0, rs: 1'b0, data: DISPLAY_ON};
                list_next[4]  = '{bare: 1'b0, rs: 1'b0, data: CLEAR_DISPLAY};
                list_cnt_next = LIST_CNT_W'(5);
              end else begin
                list_next[0]  = '{bare: 1'b0, rs: 1'b0, data: FUNC_SET_8BIT};
                list_next[1]  = '{bare: 1'b0, rs: 1'b0, data: DISPLAY_ON};
                list_next[2]  = '{bare: 1'b0, rs: 1'b0, data: CLEAR_DISPLAY};
                list_cnt_next = LIST_CNT_W'(3);
              end
              state_next = ST_LIST;
            end
            CMD_NUMBER: begin
              // most negative value negates to itself, read as unsigned
              mag_next         = num_raw[NUMBER_WIDTH-1] ? (~num_raw + 1'b1) : num_raw;
              bcd_next         = '0;
              conv_cnt_next    = CONV_CNT_W'(NUMBER_WIDTH);
              digits_left_next = DIGIT_CNT_W'(DIGITS);
              num_mode_next    = 1'b1;
              list_next[0]     = '{bare: 1'b0, rs: 1'b1, data: ASCII_MINUS};
              list_cnt_next    = {{(LIST_CNT_W-1){1'b0}}, num_raw[NUMBER_WIDTH-1]};
              state_next       = ST_CONV;
            end
            default: ;  // unknown request: no strobes
          endcase
        end
      end
      ST_CONV: begin
        bcd_next      = {bcd_adj[BCD_W-2:0], mag[NUMBER_WIDTH-1]};
        mag_next      = {mag[NUMBER_WIDTH-2:0], 1'b0};
        conv_cnt_next = conv_cnt - 1'b1;
        if (conv_cnt == CONV_CNT_W'(1)) begin
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // keep at least one digit so zero prints as '0'
        if ((top_digit == 4'd0) && (digits_left != DIGIT_CNT_W'(1))) begin
          bcd_next         = {bcd[BCD_W-5:0], 4'h0};
          digits_left_next = digits_left - 1'b1;
        end else if (list_cnt != '0) begin
          state_next = ST_LIST;
        end else begin
          state_next = ST_DIGITS;
        end
      end
      ST_LIST: begin
        if (emit) begin
          nib_phase_next = split && !nib_phase;
          if (item_done) begin
            for (int i = 0; i < LIST_DEPTH - 1; i++) begin
              list_next[i] = list[i+1];
            end
            list_cnt_next = list_cnt - 1'b1;
            if (list_cnt == LIST_CNT_W'(1)) begin
              state_next = num_mode ? ST_DIGITS : ST_IDLE;
            end
          end
        end
      end
      ST_DIGITS: begin
        if (emit) begin
          nib_phase_next = split && !nib_phase;
          if (item_done) begin
            bcd_next         = {bcd[BCD_W-5:0], 4'h0};
            digits_left_next = digits_left - 1'b1;
            if (digits_left == DIGIT_CNT_W'(1)) begin
              state_next = ST_IDLE;
            end
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      bus_mode  <= 1'b1;
      m_tvalid  <= 1'b0;
      num_mode  <= 1'b0;
      list_cnt  <= '0;
      nib_phase <= 1'b0;
    end else begin
      state     <= state_next;
      num_mode  <= num_mode_next;
      list_cnt  <= list_cnt_next;
      nib_phase <= nib_phase_next;
      if (cfg_wr_en) begin
        bus_mode <= cfg_wr_data;
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    conv_cnt    <= conv_cnt_next;
    mag         <= mag_next;
    bcd         <= bcd_next;
    digits_left <= digits_left_next;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      list[i] <= list_next[i];
    end
    if (emit) begin
      m_tdata <= cur_val;
      m_tuser <= cur.rs;
      m_tlast <= strobe_last;
    end
  end

  // Final strobe of a request always hands control back to idle.
  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (emit && strobe_last) |=> (state == ST_IDLE))
    else $error("last strobe did not end the request");

  a_digits_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIGITS) |-> (digits_left != '0))
    else $error("digit phase with no digits left");

  a_list_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LIST) |-> (list_cnt != '0))
    else $error("list phase with empty list");

  a_number_converts: assert property (@(posedge clk) disable iff (rst)
    (accept && (s_tuser == CMD_NUMBER)) |=> ((state == ST_CONV) && (conv_cnt != '0)))
    else $error("number request did not start conversion");

endmodule
